>>> hw/rtl/jsu_pkg.sv
package jsu_pkg;

  typedef enum logic [1:0] {
    KIND_BYTE = 2'd0,
    KIND_DONE = 2'd1,
    KIND_ERR  = 2'd2
  } kind_e;

  typedef enum logic [2:0] {
    ERR_NONE        = 3'd0,
    ERR_NO_QUOTE    = 3'd1,
    ERR_CTRL_BYTE   = 3'd2,
    ERR_BAD_ESCAPE  = 3'd3,
    ERR_BAD_HEX     = 3'd4,
    ERR_MISS_SECOND = 3'd5,
    ERR_BAD_LOW     = 3'd6,
    ERR_UNTERM      = 3'd7
  } err_e;

  typedef enum logic [1:0] {
    CMD_BYTE = 2'd0,
    CMD_CP   = 2'd1,
    CMD_DONE = 2'd2,
    CMD_ERR  = 2'd3
  } cmd_op_e;

  localparam int unsigned CpWidth = 21;

  typedef struct packed {
    cmd_op_e              op;
    err_e                 err;
    logic [CpWidth-1:0]   value;
  } cmd_t;

  typedef struct packed {
    logic [7:0] out_byte;
    kind_e      kind;
    err_e       err;
    logic       last;
  } result_t;

  localparam logic [7:0] ChQuote  = 8'h22;
  localparam logic [7:0] ChBslash = 8'h5C;
  localparam logic [7:0] ChSlash  = 8'h2F;
  localparam logic [7:0] ChB      = 8'h62;
  localparam logic [7:0] ChF      = 8'h66;
  localparam logic [7:0] ChN      = 8'h6E;
  localparam logic [7:0] ChR      = 8'h72;
  localparam logic [7:0] ChT      = 8'h74;
  localparam logic [7:0] ChU      = 8'h75;
  localparam logic [7:0] CtrlLimit = 8'h20;

  localparam logic [5:0] HighTag = 6'b110110;
  localparam logic [5:0] LowTag  = 6'b110111;
  localparam logic [CpWidth-1:0] PairBase = 21'h10000;

  localparam logic [CpWidth-1:0] Max1 = 21'h7F;
  localparam logic [CpWidth-1:0] Max2 = 21'h7FF;
  localparam logic [CpWidth-1:0] Max3 = 21'hFFFF;

  localparam logic [7:0] Lead2 = 8'hC0;
  localparam logic [7:0] Lead3 = 8'hE0;
  localparam logic [7:0] Lead4 = 8'hF0;
  localparam logic [7:0] Cont  = 8'h80;

  function automatic logic [4:0] hex_value(input logic [7:0] c);
    logic [4:0] r;
    r = 5'h10;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b0, c[3:0]};
    end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
      r = {1'b0, 4'(c[3:0] + 4'd9)};
    end
    return r;
  endfunction

endpackage

>>> hw/rtl/json_string_unescape_core.sv
// A request's results pass through the command queue and then the output register to m_axis.
// Throughput: one input request per cycle; results leave at one per cycle while m_axis_tready
// is high; a \u escape yields 1 to 4, so the back end's byte serializer sets the output rate.
// The command queue (QueueDepth entries) absorbs those bursts; s_axis_tready drops when full.
// Reset: rst_ni is asynchronous and active low; it returns the parser to idle and empties
// the queue and the output register. No clearing pass follows reset.
module json_string_unescape_core #(
  parameter int unsigned QueueDepth = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,  // [7:0] data_byte
  input  logic        s_axis_tuser,  // [0] func
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,  // [7:0] out_byte, [10:8] error_code, [15:11] zero
  output logic [1:0]  m_axis_tuser,  // [1:0] kind
  output logic        m_axis_tlast
);

  logic             push, q_full, q_valid, pop;
  jsu_pkg::cmd_t    cmd_in, cmd_out;
  jsu_pkg::result_t res;

  jsu_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .in_byte_i  (s_axis_tdata),
    .in_end_i   (s_axis_tuser),
    .q_full_i   (q_full),
    .push_o     (push),
    .cmd_o      (cmd_in)
  );

  jsu_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (cmd_in),
    .full_o  (q_full),
    .pop_i   (pop),
    .valid_o (q_valid),
    .data_o  (cmd_out)
  );

  jsu_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .cmd_i       (cmd_out),
    .pop_o       (pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_o       (res)
  );

  assign m_axis_tdata = {5'd0, res.err, res.out_byte};
  assign m_axis_tuser = res.kind;
  assign m_axis_tlast = res.last;

endmodule

>>> hw/rtl/jsu_front.sv
module jsu_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  logic [7:0]    in_byte_i,
  input  logic          in_end_i,
  input  logic          q_full_i,
  output logic          push_o,
  output jsu_pkg::cmd_t cmd_o
);

  typedef enum logic [2:0] {
    M_IDLE = 3'd0,
    M_STR  = 3'd1,
    M_ESC  = 3'd2,
    M_HEX1 = 3'd3,
    M_BSL2 = 3'd4,
    M_U2   = 3'd5,
    M_HEX2 = 3'd6
  } mode_e;

  mode_e       mode_q, mode_d;
  logic [1:0]  cnt_q, cnt_d;
  logic [11:0] acc_q, acc_d;
  logic [9:0]  hs_q, hs_d;

  logic                          accept;
  logic [4:0]                    hv;
  logic [15:0]                   cp16;
  logic [jsu_pkg::CpWidth-1:0]   pair_cp;

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && !q_full_i;
  assign hv         = jsu_pkg::hex_value(in_byte_i);
  assign cp16       = {acc_q, hv[3:0]};
  assign pair_cp    = jsu_pkg::PairBase + {1'b0, hs_q, cp16[9:0]};

  always_comb begin
    mode_d    = mode_q;
    cnt_d     = cnt_q;
    acc_d     = acc_q;
    hs_d      = hs_q;
    push_o    = 1'b0;
    cmd_o.op    = jsu_pkg::CMD_BYTE;
    cmd_o.err   = jsu_pkg::ERR_NONE;
    cmd_o.value = {13'd0, in_byte_i};
    if (accept) begin
      if (in_end_i) begin
        push_o    = 1'b1;
        cmd_o.op  = jsu_pkg::CMD_ERR;
        cmd_o.err = (mode_q != M_IDLE) ? jsu_pkg::ERR_UNTERM : jsu_pkg::ERR_NO_QUOTE;
        mode_d    = M_IDLE;
      end else begin
        unique case (mode_q)
          M_STR: begin
            if (in_byte_i == jsu_pkg::ChQuote) begin
              push_o   = 1'b1;
              cmd_o.op = jsu_pkg::CMD_DONE;
              mode_d   = M_IDLE;
            end else if (in_byte_i == jsu_pkg::ChBslash) begin
              mode_d = M_ESC;
            end else if (in_byte_i < jsu_pkg::CtrlLimit) begin
              push_o    = 1'b1;
              cmd_o.op  = jsu_pkg::CMD_ERR;
              cmd_o.err = jsu_pkg::ERR_CTRL_BYTE;
              mode_d    = M_IDLE;
            end else begin
              push_o = 1'b1;
            end
          end
          M_ESC: begin
            mode_d = M_STR;
            push_o = 1'b1;
            unique case (in_byte_i)
              jsu_pkg::ChQuote, jsu_pkg::ChBslash, jsu_pkg::ChSlash: begin
              end
              jsu_pkg::ChB: cmd_o.value = 21'h08;
              jsu_pkg::ChF: cmd_o.value = 21'h0C;
              jsu_pkg::ChN: cmd_o.value = 21'h0A;
              jsu_pkg::ChR: cmd_o.value = 21'h0D;
              jsu_pkg::ChT: cmd_o.value = 21'h09;
              jsu_pkg::ChU: begin
                push_o = 1'b0;
                mode_d = M_HEX1;
                cnt_d  = 2'd0;
              end
              default: begin
                cmd_o.op  = jsu_pkg::CMD_ERR;
                cmd_o.err = jsu_pkg::ERR_BAD_ESCAPE;
                mode_d    = M_IDLE;
              end
            endcase
          end
          M_HEX1, M_HEX2: begin
            if (hv[4]) begin
              push_o    = 1'b1;
              cmd_o.op  = jsu_pkg::CMD_ERR;
              cmd_o.err = jsu_pkg::ERR_BAD_HEX;
              mode_d    = M_IDLE;
            end else if (cnt_q != 2'd3) begin
              cnt_d = cnt_q + 2'd1;
              acc_d = cp16[11:0];
            end else begin
              cnt_d = 2'd0;
              if (mode_q == M_HEX1) begin
                if (cp16[15:10] == jsu_pkg::HighTag) begin
                  hs_d   = cp16[9:0];
                  mode_d = M_BSL2;
                end else begin
                  push_o      = 1'b1;
                  cmd_o.op    = jsu_pkg::CMD_CP;
                  cmd_o.value = {5'd0, cp16};
                  mode_d      = M_STR;
                end
              end else if (cp16[15:10] != jsu_pkg::LowTag) begin
                push_o    = 1'b1;
                cmd_o.op  = jsu_pkg::CMD_ERR;
                cmd_o.err = jsu_pkg::ERR_BAD_LOW;
                mode_d    = M_IDLE;
              end else begin
                push_o      = 1'b1;
                cmd_o.op    = jsu_pkg::CMD_CP;
                cmd_o.value = pair_cp;
                mode_d      = M_STR;
              end
            end
          end
          M_BSL2: begin
            if (in_byte_i == jsu_pkg::ChBslash) begin
              mode_d = M_U2;
            end else begin
              push_o    = 1'b1;
              cmd_o.op  = jsu_pkg::CMD_ERR;
              cmd_o.err = jsu_pkg::ERR_MISS_SECOND;
              mode_d    = M_IDLE;
            end
          end
          M_U2: begin
            if (in_byte_i == jsu_pkg::ChU) begin
              mode_d = M_HEX2;
              cnt_d  = 2'd0;
            end else begin
              push_o    = 1'b1;
              cmd_o.op  = jsu_pkg::CMD_ERR;
              cmd_o.err = jsu_pkg::ERR_MISS_SECOND;
              mode_d    = M_IDLE;
            end
          end
          default: begin
            if (in_byte_i == jsu_pkg::ChQuote) begin
              mode_d = M_STR;
            end else begin
              push_o    = 1'b1;
              cmd_o.op  = jsu_pkg::CMD_ERR;
              cmd_o.err = jsu_pkg::ERR_NO_QUOTE;
            end
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= M_IDLE;
      cnt_q  <= 2'd0;
      acc_q  <= 12'd0;
      hs_q   <= 10'd0;
    end else begin
      mode_q <= mode_d;
      cnt_q  <= cnt_d;
      acc_q  <= acc_d;
      hs_q   <= hs_d;
    end
  end

endmodule

>>> hw/rtl/jsu_queue.sv
module jsu_queue #(
  parameter int unsigned Depth = 4
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  jsu_pkg::cmd_t data_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          valid_o,
  output jsu_pkg::cmd_t data_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] Full    = CntW'(Depth);

  jsu_pkg::cmd_t  mem [Depth];
  logic [PtrW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_push, do_pop;

  assign full_o  = (cnt_q == Full);
  assign valid_o = (cnt_q != '0);
  assign data_o  = mem[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == LastPtr) ? '0 : wr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_d = (rd_q == LastPtr) ? '0 : rd_q + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (!do_push && do_pop) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem[wr_q] <= data_i;
    end
  end

endmodule

>>> hw/rtl/jsu_back.sv
module jsu_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             q_valid_i,
  input  jsu_pkg::cmd_t    cmd_i,
  output logic             pop_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output jsu_pkg::result_t out_o
);

  logic [1:0]                  idx_q, idx_d;
  logic [1:0]                  last_idx;
  logic                        load;
  logic [jsu_pkg::CpWidth-1:0] v;
  logic                        out_valid_q;
  jsu_pkg::result_t            res_d, res_q;

  assign v = cmd_i.value;

  always_comb begin
    last_idx = 2'd0;
    if (cmd_i.op == jsu_pkg::CMD_CP) begin
      priority if (v <= jsu_pkg::Max1) begin
        last_idx = 2'd0;
      end else if (v <= jsu_pkg::Max2) begin
        last_idx = 2'd1;
      end else if (v <= jsu_pkg::Max3) begin
        last_idx = 2'd2;
      end else begin
        last_idx = 2'd3;
      end
    end
  end

  assign load  = q_valid_i && (!out_valid_q || out_ready_i);
  assign pop_o = load && (idx_q == last_idx);
  assign idx_d = pop_o ? 2'd0 : (load ? idx_q + 2'd1 : idx_q);

  always_comb begin
    res_d.out_byte = 8'd0;
    res_d.kind     = jsu_pkg::KIND_BYTE;
    res_d.err      = jsu_pkg::ERR_NONE;
    res_d.last     = (idx_q == last_idx);
    unique case (cmd_i.op)
      jsu_pkg::CMD_BYTE: res_d.out_byte = v[7:0];
      jsu_pkg::CMD_DONE: res_d.kind = jsu_pkg::KIND_DONE;
      jsu_pkg::CMD_ERR: begin
        res_d.kind = jsu_pkg::KIND_ERR;
        res_d.err  = cmd_i.err;
      end
      jsu_pkg::CMD_CP: begin
        unique case ({last_idx, idx_q})
          4'b00_00: res_d.out_byte = v[7:0];
          4'b01_00: res_d.out_byte = jsu_pkg::Lead2 | {3'd0, v[10:6]};
          4'b01_01: res_d.out_byte = jsu_pkg::Cont | {2'd0, v[5:0]};
          4'b10_00: res_d.out_byte = jsu_pkg::Lead3 | {4'd0, v[15:12]};
          4'b10_01: res_d.out_byte = jsu_pkg::Cont | {2'd0, v[11:6]};
          4'b10_10: res_d.out_byte = jsu_pkg::Cont | {2'd0, v[5:0]};
          4'b11_00: res_d.out_byte = jsu_pkg::Lead4 | {5'd0, v[20:18]};
          4'b11_01: res_d.out_byte = jsu_pkg::Cont | {2'd0, v[17:12]};
          4'b11_10: res_d.out_byte = jsu_pkg::Cont | {2'd0, v[11:6]};
          4'b11_11: res_d.out_byte = jsu_pkg::Cont | {2'd0, v[5:0]};
          default:  res_d.out_byte = 8'd0;
        endcase
      end
      default: res_d.out_byte = 8'd0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= 2'd0;
      out_valid_q <= 1'b0;
    end else begin
      idx_q <= idx_d;
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = res_q;

endmodule

>>> hw/rtl/jsu_checker.sv
module jsu_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [15:0] m_axis_tdata,
  input logic [1:0]  m_axis_tuser,
  input logic        m_axis_tlast
);

  localparam logic [1:0] KByte = 2'(jsu_pkg::KIND_BYTE);
  localparam logic [1:0] KErr  = 2'(jsu_pkg::KIND_ERR);
  localparam logic [1:0] KDone = 2'(jsu_pkg::KIND_DONE);

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast))
    else $error("stalled result changed");

  a_end_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser != KByte |-> m_axis_tlast)
    else $error("completion or error result not marked last");

  a_err_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> ((m_axis_tuser == KErr) == (m_axis_tdata[10:8] != 3'd0)))
    else $error("error code does not match kind");

  a_zero_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser != KByte |-> m_axis_tdata[7:0] == 8'd0)
    else $error("nonzero byte on status result");

  a_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tuser == KByte || m_axis_tuser == KDone ||
                       m_axis_tuser == KErr) && m_axis_tdata[15:11] == 5'd0)
    else $error("invalid kind or padding");

endmodule

bind json_string_unescape_core jsu_checker u_jsu_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);

>>> dv/json_string_unescape_core_tb.sv
module json_string_unescape_core_tb;

  typedef enum logic [2:0] {
    PS_IDLE,
    PS_TEXT,
    PS_ESC,
    PS_HEX_A,
    PS_BSL_B,
    PS_U_B,
    PS_HEX_B
  } parse_e;

  typedef struct packed {
    logic           func;
    logic [7:0]     data;
    logic           typed;
    logic           has_res;
    jsu_pkg::kind_e kind;
    jsu_pkg::err_e  err;
    logic [7:0]     obyte;
  } req_t;

  localparam int NumDir  = 26;
  localparam int NumRand = 134;

  localparam req_t DirTab [NumDir] = '{
    '{1'b1, 8'h00, 1'b1, 1'b1, jsu_pkg::KIND_ERR, jsu_pkg::ERR_NO_QUOTE, 8'h00},
    '{1'b0, 8'h00, 1'b1, 1'b1, jsu_pkg::KIND_ERR, jsu_pkg::ERR_NO_QUOTE, 8'h00},
    '{1'b0, jsu_pkg::ChQuote, 1'b1, 1'b0, jsu_pkg::KIND_BYTE, jsu_pkg::ERR_NONE, 8'h00},
    '{1'b0, 8'hFF, 1'b1, 1'b1, jsu_pkg::KIND_BYTE, jsu_pkg::ERR_NONE, 8'hFF},
    '{1'b0, jsu_pkg::ChBslash, 1'b0, 1'b0, jsu_pkg::KIND_BYTE, jsu_pkg::ERR_NONE, 8'h00},
    '{1'b0, jsu_pkg::ChSlash, 1'b0, 1'b0, jsu_pkg::KIND_BYTE, jsu_pkg::ERR_NONE, 8'h00},
    '{1'b0, 8'h1F, 1'b1, 1'b1, jsu_pkg::KIND_ERR, jsu_pkg::ERR_CTRL_BYTE, 8'h00},
    '{1'b0, jsu_pkg::ChQuote, 1'b1, 1'b0, jsu_pkg::KIND_BYTE, jsu_pkg::ERR_NONE, 8'h00},
    '{1'b0, jsu_pkg::ChBslash, 1'b0, 1'b0, jsu_pkg::KIND_BYTE, jsu_pkg::ERR_NONE, 8'h00},
    '{1'b0, 8'h71, 1'b1, 1'b1, jsu_pkg::KIND_ERR, jsu_pkg::ERR_BAD_ESCAPE, 8'h00},
    '{1'b0, jsu_pkg::ChQuote, 1'b1, 1'b0, jsu_pkg::KIND_BYTE, jsu_pkg::ERR_NONE, 8'h00},
    '{1'b0, jsu_pkg::ChBslash, 1'b0, 1'b0, jsu_pkg::KIND_BYTE, jsu_pkg::ERR_NONE, 8'h00},
    '{1'b0, jsu_pkg::ChU, 1'b0, 1'b0, jsu_pkg::KIND_BYTE, jsu_pkg::ERR_NONE, 8'h00},
    '{1'b0, 8'h30, 1'b0, 1'b0, jsu_pkg::KIND_BYTE, jsu_pkg::ERR_NONE, 8'h00},
    '{1'b0, 8'h30, 1'b0, 1'b0, jsu_pkg::KIND_BYTE, jsu_pkg::ERR_NONE, 8'h00},
    '{1'b0, 8'h30, 1'b0, 1'b0, jsu_pkg::KIND_BYTE, jsu_pkg::ERR_NONE, 8'h00},
    '{1'b0, 8'h30, 1'b0, 1'b0, jsu_pkg::KIND_BYTE, jsu_pkg::ERR_NONE, 8'h00},
    '{1'b0, jsu_pkg::ChBslash, 1'b0, 1'b0, jsu_pkg::KIND_BYTE, jsu_pkg::ERR_NONE, 8'h00},
    '{1'b0, jsu_pkg::ChU, 1'b0, 1'b0, jsu_pkg::KIND_BYTE, jsu_pkg::ERR_NONE, 8'h00},
    '{1'b0, 8'h47, 1'b1, 1'b1, jsu_pkg::KIND_ERR, jsu_pkg::ERR_BAD_HEX, 8'h00},
    '{1'b0, jsu_pkg::ChQuote, 1'b1, 1'b0, jsu_pkg::KIND_BYTE, jsu_pkg::ERR_NONE, 8'h00},
    '{1'b0, jsu_pkg::ChBslash, 1'b0, 1'b0, jsu_pkg::KIND_BYTE, jsu_pkg::ERR_NONE, 8'h00},
    '{1'b1, 8'hFF, 1'b1, 1'b1, jsu_pkg::KIND_ERR, jsu_pkg::ERR_UNTERM, 8'h00},
    '{1'b0, jsu_pkg::ChQuote, 1'b1, 1'b0, jsu_pkg::KIND_BYTE, jsu_pkg::ERR_NONE, 8'h00},
    '{1'b0, 8'h20, 1'b0, 1'b0, jsu_pkg::KIND_BYTE, jsu_pkg::ERR_NONE, 8'h00},
    '{1'b0, jsu_pkg::ChQuote, 1'b1, 1'b1, jsu_pkg::KIND_DONE, jsu_pkg::ERR_NONE, 8'h00}
  };

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = 8'h00;  // [7:0] data_byte
  logic        s_axis_tuser = 1'b0;   // [0] func
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;          // [7:0] out_byte, [10:8] error_code, [15:11] zero
  logic [1:0]  m_axis_tuser;          // [1:0] kind
  logic        m_axis_tlast;

  json_string_unescape_core dut (.*);

  always begin
    #10;
    clk_i = 1'b1;
    #10;
    clk_i = 1'b0;
  end

  parse_e           ps = PS_IDLE;
  logic [1:0]       digit_cnt = 2'd0;
  logic [15:0]      acc = 16'h0000;
  logic [9:0]       hi_half = 10'h000;
  jsu_pkg::result_t req_out[$];
  jsu_pkg::result_t out_due[$];
  req_t             feed_q[$];
  req_t             on_bus;
  jsu_pkg::result_t want;
  jsu_pkg::result_t exp_r;
  int               next_idx = 0;
  int               n_taken = 0;
  int               n_rand = 0;
  int               n_bad = 0;
  int               burst_left = 0;
  int               gap_left = 0;
  int               hold_left = 0;
  logic [31:0]      rx_cyc = 32'd0;

  function automatic jsu_pkg::result_t mk(input logic [7:0] b, input jsu_pkg::kind_e k,
                                          input jsu_pkg::err_e e);
    jsu_pkg::result_t r;
    r.out_byte = b;
    r.kind = k;
    r.err = e;
    r.last = 1'b0;
    return r;
  endfunction

  function automatic logic [4:0] hex_nib(input logic [7:0] c);
    if (c >= 8'h30 && c <= 8'h39) return {1'b0, 4'(c - 8'h30)};
    if (c >= 8'h61 && c <= 8'h66) return {1'b0, 4'(c - 8'h57)};
    if (c >= 8'h41 && c <= 8'h46) return {1'b0, 4'(c - 8'h37)};
    return 5'h10;
  endfunction

  task automatic emit(input jsu_pkg::result_t r);
    req_out = {req_out, r};
  endtask

  task automatic park();
    ps = PS_IDLE;
    digit_cnt = 2'd0;
    acc = 16'h0000;
    hi_half = 10'h000;
  endtask

  task automatic fail_to_idle(input jsu_pkg::err_e e);
    park();
    emit(mk(8'h00, jsu_pkg::KIND_ERR, e));
  endtask

  task automatic put_utf8(input logic [20:0] cp);
    if (cp <= jsu_pkg::Max1) begin
      emit(mk(cp[7:0], jsu_pkg::KIND_BYTE, jsu_pkg::ERR_NONE));
    end else if (cp <= jsu_pkg::Max2) begin
      emit(mk({3'b110, cp[10:6]}, jsu_pkg::KIND_BYTE, jsu_pkg::ERR_NONE));
      emit(mk({2'b10, cp[5:0]}, jsu_pkg::KIND_BYTE, jsu_pkg::ERR_NONE));
    end else if (cp <= jsu_pkg::Max3) begin
      emit(mk({4'b1110, cp[15:12]}, jsu_pkg::KIND_BYTE, jsu_pkg::ERR_NONE));
      emit(mk({2'b10, cp[11:6]}, jsu_pkg::KIND_BYTE, jsu_pkg::ERR_NONE));
      emit(mk({2'b10, cp[5:0]}, jsu_pkg::KIND_BYTE, jsu_pkg::ERR_NONE));
    end else begin
      emit(mk({5'b11110, cp[20:18]}, jsu_pkg::KIND_BYTE, jsu_pkg::ERR_NONE));
      emit(mk({2'b10, cp[17:12]}, jsu_pkg::KIND_BYTE, jsu_pkg::ERR_NONE));
      emit(mk({2'b10, cp[11:6]}, jsu_pkg::KIND_BYTE, jsu_pkg::ERR_NONE));
      emit(mk({2'b10, cp[5:0]}, jsu_pkg::KIND_BYTE, jsu_pkg::ERR_NONE));
    end
  endtask

  task automatic unescape_req(input logic func, input logic [7:0] c);
    logic [4:0]  nib;
    logic [20:0] cp;
    req_out.delete();
    if (func) begin
      if (ps == PS_IDLE) fail_to_idle(jsu_pkg::ERR_NO_QUOTE);
      else fail_to_idle(jsu_pkg::ERR_UNTERM);
    end else begin
      case (ps)
        PS_TEXT: begin
          if (c == jsu_pkg::ChQuote) begin
            park();
            emit(mk(8'h00, jsu_pkg::KIND_DONE, jsu_pkg::ERR_NONE));
          end else if (c == jsu_pkg::ChBslash) begin
            ps = PS_ESC;
          end else if (c < jsu_pkg::CtrlLimit) begin
            fail_to_idle(jsu_pkg::ERR_CTRL_BYTE);
          end else begin
            emit(mk(c, jsu_pkg::KIND_BYTE, jsu_pkg::ERR_NONE));
          end
        end
        PS_ESC: begin
          ps = PS_TEXT;
          case (c)
            jsu_pkg::ChQuote, jsu_pkg::ChBslash, jsu_pkg::ChSlash:
              emit(mk(c, jsu_pkg::KIND_BYTE, jsu_pkg::ERR_NONE));
            jsu_pkg::ChB: emit(mk(8'h08, jsu_pkg::KIND_BYTE, jsu_pkg::ERR_NONE));
            jsu_pkg::ChF: emit(mk(8'h0C, jsu_pkg::KIND_BYTE, jsu_pkg::ERR_NONE));
            jsu_pkg::ChN: emit(mk(8'h0A, jsu_pkg::KIND_BYTE, jsu_pkg::ERR_NONE));
            jsu_pkg::ChR: emit(mk(8'h0D, jsu_pkg::KIND_BYTE, jsu_pkg::ERR_NONE));
            jsu_pkg::ChT: emit(mk(8'h09, jsu_pkg::KIND_BYTE, jsu_pkg::ERR_NONE));
            jsu_pkg::ChU: begin
              ps = PS_HEX_A;
              digit_cnt = 2'd0;
              acc = 16'h0000;
            end
            default: fail_to_idle(jsu_pkg::ERR_BAD_ESCAPE);
          endcase
        end
        PS_HEX_A, PS_HEX_B: begin
          nib = hex_nib(c);
          if (nib[4]) begin
            fail_to_idle(jsu_pkg::ERR_BAD_HEX);
          end else begin
            acc = {acc[11:0], nib[3:0]};
            if (digit_cnt != 2'd3) begin
              digit_cnt = digit_cnt + 2'd1;
            end else begin
              digit_cnt = 2'd0;
              if (ps == PS_HEX_A) begin
                if (acc >= 16'hD800 && acc <= 16'hDBFF) begin
                  hi_half = acc[9:0];
                  ps = PS_BSL_B;
                end else begin
                  ps = PS_TEXT;
                  put_utf8({5'd0, acc});
                end
              end else if (acc < 16'hDC00 || acc > 16'hDFFF) begin
                fail_to_idle(jsu_pkg::ERR_BAD_LOW);
              end else begin
                cp = jsu_pkg::PairBase + {1'b0, hi_half, acc[9:0]};
                hi_half = 10'h000;
                ps = PS_TEXT;
                put_utf8(cp);
              end
              acc = 16'h0000;
            end
          end
        end
        PS_BSL_B: begin
          if (c != jsu_pkg::ChBslash) fail_to_idle(jsu_pkg::ERR_MISS_SECOND);
          else ps = PS_U_B;
        end
        PS_U_B: begin
          if (c != jsu_pkg::ChU) begin
            fail_to_idle(jsu_pkg::ERR_MISS_SECOND);
          end else begin
            ps = PS_HEX_B;
            digit_cnt = 2'd0;
            acc = 16'h0000;
          end
        end
        default: begin
          if (c != jsu_pkg::ChQuote) begin
            fail_to_idle(jsu_pkg::ERR_NO_QUOTE);
          end else begin
            park();
            ps = PS_TEXT;
          end
        end
      endcase
    end
    if (req_out.size() != 0) begin
      req_out[req_out.size() - 1].last = 1'b1;
    end
  endtask

  task automatic add_req(input logic func, input logic [7:0] c);
    req_t r;
    r = '0;
    r.func = func;
    r.data = c;
    feed_q = {feed_q, r};
    n_rand++;
  endtask

  function automatic logic [7:0] hex_char(input logic [3:0] v);
    if (v < 4'd10) return 8'h30 + {4'd0, v};
    return ($urandom_range(0, 1) ? 8'h61 : 8'h41) + {4'd0, v} - 8'd10;
  endfunction

  function automatic logic [7:0] non_hex();
    logic [7:0] c;
    logic [4:0] nib;
    do begin
      c = 8'($urandom_range(0, 255));
      nib = hex_nib(c);
    end while (!nib[4]);
    return c;
  endfunction

  task automatic add_u16(input logic [15:0] v, input bit spoil);
    int bad;
    bad = spoil ? $urandom_range(0, 3) : 4;
    add_req(1'b0, jsu_pkg::ChBslash);
    add_req(1'b0, jsu_pkg::ChU);
    for (int i = 3; i >= 0; i--) begin
      if (3 - i == bad) begin
        add_req(1'b0, non_hex());
        return;
      end
      add_req(1'b0, hex_char(v[4*i +: 4]));
    end
  endtask

  function automatic logic [15:0] pick_half(input logic [15:0] base);
    case ($urandom_range(0, 3))
      0: return base;
      1: return base + 16'h03FF;
      default: return base + 16'($urandom_range(0, 1023));
    endcase
  endfunction

  task automatic gen_literal();
    int          segs;
    bit          alive;
    bit          spoil;
    logic [7:0]  c;
    logic [15:0] hi;
    logic [15:0] lo;
    segs = $urandom_range(0, 6);
    alive = 1'b1;
    add_req(1'b0, jsu_pkg::ChQuote);
    for (int s = 0; s < segs && alive; s++) begin
      case ($urandom_range(0, 15))
        0, 1, 2, 3, 4, 5: begin
          do c = 8'($urandom_range(32, 255));
          while (c == jsu_pkg::ChQuote || c == jsu_pkg::ChBslash);
          add_req(1'b0, c);
        end
        6, 7: begin
          add_req(1'b0, jsu_pkg::ChBslash);
          case ($urandom_range(0, 8))
            0: c = jsu_pkg::ChQuote;
            1: c = jsu_pkg::ChBslash;
            2: c = jsu_pkg::ChSlash;
            3: c = jsu_pkg::ChB;
            4: c = jsu_pkg::ChF;
            5: c = jsu_pkg::ChN;
            6: c = jsu_pkg::ChR;
            7: c = jsu_pkg::ChT;
            default: begin
              c = 8'($urandom_range(0, 255));
              alive = 1'b0;
            end
          endcase
          add_req(1'b0, c);
        end
        8, 9: begin
          case ($urandom_range(0, 4))
            0: hi = 16'($urandom_range(0, 16'h7F));
            1: hi = 16'($urandom_range(16'h80, 16'h7FF));
            2: hi = 16'($urandom_range(16'h800, 16'hD7FF));
            3: hi = 16'($urandom_range(16'hE000, 16'hFFFF));
            default: hi = pick_half(16'hDC00);
          endcase
          spoil = ($urandom_range(0, 7) == 0);
          add_u16(hi, spoil);
          if (spoil) alive = 1'b0;
        end
        10, 11: begin
          add_u16(pick_half(16'hD800), 1'b0);
          add_u16(pick_half(16'hDC00), 1'b0);
        end
        12: begin
          add_u16(pick_half(16'hD800), 1'b0);
          case ($urandom_range(0, 4))
            0: begin
              do c = 8'($urandom_range(0, 255)); while (c == jsu_pkg::ChBslash);
              add_req(1'b0, c);
            end
            1: begin
              add_req(1'b0, jsu_pkg::ChBslash);
              do c = 8'($urandom_range(0, 255)); while (c == jsu_pkg::ChU);
              add_req(1'b0, c);
            end
            2: begin
              do lo = 16'($urandom_range(0, 16'hFFFF));
              while (lo >= 16'hDC00 && lo <= 16'hDFFF);
              add_u16(lo, 1'b0);
            end
            3: add_u16(pick_half(16'hDC00), 1'b1);
            default: add_req(1'b1, 8'($urandom_range(0, 255)));
          endcase
          alive = 1'b0;
        end
        13: begin
          add_req(1'b0, 8'($urandom_range(0, 31)));
          alive = 1'b0;
        end
        14: begin
          add_req(1'b1, 8'($urandom_range(0, 255)));
          alive = 1'b0;
        end
        default: begin
          add_req(1'b0, jsu_pkg::ChBslash);
          add_req(1'b1, 8'($urandom_range(0, 255)));
          alive = 1'b0;
        end
      endcase
    end
    if (alive) begin
      if ($urandom_range(0, 7) != 0) add_req(1'b0, jsu_pkg::ChQuote);
      else add_req(1'b1, 8'($urandom_range(0, 255)));
    end
  endtask

  task automatic gen_noise();
    int cnt;
    cnt = $urandom_range(1, 3);
    repeat (cnt) add_req($urandom_range(0, 3) == 0, 8'($urandom_range(0, 255)));
  endtask

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        unescape_req(on_bus.func, on_bus.data);
        if (on_bus.typed) begin
          req_out.delete();
          if (on_bus.has_res) begin
            want = mk(on_bus.obyte, on_bus.kind, on_bus.err);
            want.last = 1'b1;
            emit(want);
          end
        end
        out_due = {out_due, req_out};
        n_taken++;
      end
      // hold the request until taken
      if (!s_axis_tvalid || s_axis_tready) begin
        if (gap_left > 0) begin
          gap_left--;
          s_axis_tvalid <= 1'b0;
        end else if (next_idx < feed_q.size()) begin
          on_bus = feed_q[next_idx];
          next_idx++;
          s_axis_tvalid <= 1'b1;
          s_axis_tdata <= on_bus.data;
          s_axis_tuser <= on_bus.func;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(0, 15);
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 5);
          end
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      rx_cyc <= rx_cyc + 32'd1;
      // long hold-off so the queue fills and the input stalls
      if (rx_cyc == 32'd120) hold_left = 150;
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        case (rx_cyc[7:6])
          2'd0: m_axis_tready <= 1'b1;
          2'd1: m_axis_tready <= 1'($urandom_range(0, 1));
          2'd2: m_axis_tready <= (rx_cyc[1:0] == 2'd0);
          default: m_axis_tready <= ($urandom_range(0, 3) != 0);
        endcase
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (out_due.size() == 0) begin
        $error("unexpected result: tdata %h tuser %0d tlast %b",
               m_axis_tdata, m_axis_tuser, m_axis_tlast);
        n_bad++;
      end else begin
        exp_r = out_due.pop_front();
        if (m_axis_tdata[7:0] !== exp_r.out_byte) begin
          $error("out_byte: expected %h, got %h", exp_r.out_byte, m_axis_tdata[7:0]);
          n_bad++;
        end
        if (m_axis_tuser !== exp_r.kind) begin
          $error("kind: expected %0d, got %0d", exp_r.kind, m_axis_tuser);
          n_bad++;
        end
        if (m_axis_tdata[10:8] !== exp_r.err) begin
          $error("error_code: expected %0d, got %0d", exp_r.err, m_axis_tdata[10:8]);
          n_bad++;
        end
        if (m_axis_tlast !== exp_r.last) begin
          $error("last: expected %b, got %b", exp_r.last, m_axis_tlast);
          n_bad++;
        end
        if (m_axis_tdata[15:11] !== 5'd0) begin
          $error("tdata pad: expected 0, got %h", m_axis_tdata[15:11]);
          n_bad++;
        end
      end
    end
  end

  initial begin
    foreach (DirTab[i]) feed_q = {feed_q, DirTab[i]};
    while (n_rand < NumRand) begin
      if ($urandom_range(0, 9) == 0) gen_noise();
      else gen_literal();
    end
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    while (n_taken < feed_q.size()) @(posedge clk_i);
    while (out_due.size() != 0) @(posedge clk_i);
    repeat (16) @(posedge clk_i);
    if (n_bad == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
